FILE: rtl/json_string_unescape_assert.svh
// assertion macros used by the port-level checker file
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define JSU_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// next-cycle implication, quiet during reset
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

FILE: rtl/jsu_pkg.sv
// types, codes and helper functions of the json string unescaper
package jsu_pkg;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_STR  = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_t;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NO_QUOTE = 3'd0;
  localparam logic [2:0] ERR_UNTERM   = 3'd1;
  localparam logic [2:0] ERR_ESCAPE   = 3'd2;
  localparam logic [2:0] ERR_HEX      = 3'd3;
  localparam logic [2:0] ERR_CONTROL  = 3'd4;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;
  localparam logic [7:0]  LEAD_TWO     = 8'hC0;
  localparam logic [7:0]  LEAD_THREE   = 8'hE0;
  localparam logic [7:0]  CONT_MARK    = 8'h80;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  hex_seen;
    logic [15:0] code_point;
  } dec_state_t;

  localparam dec_state_t DEC_RESET = '{phase: PH_WAIT, hex_seen: 2'd0, code_point: 16'd0};

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [1:0] count;
    logic [1:0] kind;
    logic [2:0] error_code;
  } result_t;

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

  // bit 8 set means unknown escape letter
  function automatic logic [8:0] escape_byte(input logic [7:0] c);
    logic [8:0] v;
    unique case (c)
      8'h22:   v = 9'h022;
      8'h5C:   v = 9'h05C;
      8'h2F:   v = 9'h02F;
      8'h62:   v = 9'h008;
      8'h66:   v = 9'h00C;
      8'h6E:   v = 9'h00A;
      8'h72:   v = 9'h00D;
      8'h74:   v = 9'h009;
      default: v = 9'h100;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/jsu_step.sv
// next-state and result logic for one text byte
module jsu_step (
  input  jsu_pkg::dec_state_t st,
  input  logic [7:0]          in_byte,
  input  logic                end_of_text,
  output jsu_pkg::dec_state_t st_next,
  output jsu_pkg::result_t    res,
  output logic                res_valid
);
  import jsu_pkg::*;

  logic [4:0]  hv;
  logic [8:0]  ev;
  logic [15:0] cp;

  assign hv = hex_value(in_byte);
  assign ev = escape_byte(in_byte);
  assign cp = {st.code_point[11:0], hv[3:0]};

  always_comb begin
    st_next   = st;
    res       = '0;
    res_valid = 1'b0;
    unique case (st.phase)
      PH_WAIT: begin
        if (!end_of_text) begin
          if (in_byte == CH_QUOTE) begin
            st_next.phase = PH_STR;
          end else begin
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_NO_QUOTE;
          end
        end
      end
      PH_STR: begin
        if (end_of_text) begin
          st_next        = DEC_RESET;
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_UNTERM;
        end else if (in_byte == CH_QUOTE) begin
          st_next.phase = PH_WAIT;
          res_valid     = 1'b1;
          res.kind      = KIND_CLOSE;
        end else if (in_byte == CH_BSLASH) begin
          st_next.phase = PH_ESC;
        end else if (in_byte < CTRL_LIMIT) begin
          st_next        = DEC_RESET;
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_CONTROL;
        end else begin
          res_valid = 1'b1;
          res.byte0 = in_byte;
          res.count = 2'd1;
        end
      end
      PH_ESC: begin
        if (end_of_text) begin
          st_next        = DEC_RESET;
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_UNTERM;
        end else if (in_byte == CH_U) begin
          st_next.phase      = PH_HEX;
          st_next.hex_seen   = 2'd0;
          st_next.code_point = 16'd0;
        end else if (ev[8]) begin
          st_next        = DEC_RESET;
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_ESCAPE;
        end else begin
          st_next.phase = PH_STR;
          res_valid     = 1'b1;
          res.byte0     = ev[7:0];
          res.count     = 2'd1;
        end
      end
      PH_HEX: begin
        if (end_of_text) begin
          st_next        = DEC_RESET;
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_UNTERM;
        end else if (hv[4]) begin
          st_next        = DEC_RESET;
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_HEX;
        end else if (st.hex_seen != 2'd3) begin
          st_next.code_point = cp;
          st_next.hex_seen   = st.hex_seen + 2'd1;
        end else begin
          st_next       = DEC_RESET;
          st_next.phase = PH_STR;
          res_valid     = 1'b1;
          if (cp < CP_ONE_LIMIT) begin
            res.byte0 = cp[7:0];
            res.count = 2'd1;
          end else if (cp < CP_TWO_LIMIT) begin
            res.byte0 = LEAD_TWO | {3'b000, cp[10:6]};
            res.byte1 = CONT_MARK | {2'b00, cp[5:0]};
            res.count = 2'd2;
          end else begin
            res.byte0 = LEAD_THREE | {4'b0000, cp[15:12]};
            res.byte1 = CONT_MARK | {2'b00, cp[11:6]};
            res.byte2 = CONT_MARK | {2'b00, cp[5:0]};
            res.count = 2'd3;
          end
        end
      end
      default: begin
        st_next = DEC_RESET;
      end
    endcase
  end

endmodule

FILE: rtl/json_string_unescape.sv
// top level: streaming json string literal unescaper with utf-8 output
// a byte is captured in the input register, decoded from there, and its result word is captured in the result register
// throughput: one text byte per cycle while the output is not stalled, bounded by the decoder state update
// bytes that produce no result (opening quote, backslash, the u, first hex digits) leave no output word
// reset: synchronous active-high rst empties both registers and returns the decoder
// to waiting for an opening quote with the hex count and code point cleared
module json_string_unescape (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] byte0,
  output logic [7:0] byte1,
  output logic [7:0] byte2,
  output logic [1:0] count,
  output logic [1:0] kind,
  output logic [2:0] error_code
);
  import jsu_pkg::*;

  // input register
  logic       in_reg_valid;
  logic [7:0] in_reg_byte;
  logic       in_reg_eot;

  // decoder state, updated once per byte leaving the input register
  dec_state_t st;
  dec_state_t st_next;

  // result register
  result_t    res_q;
  result_t    res_next;
  logic       res_fire;

  logic       advance;

  // the result register can take a new word when empty or being drained
  assign advance  = !out_valid || !out_stall;
  // the input register only holds when its word cannot move on
  assign in_stall = in_reg_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_reg_byte <= in_byte;
      in_reg_eot  <= end_of_text;
    end
  end

  jsu_step u_step (
    .st          (st),
    .in_byte     (in_reg_byte),
    .end_of_text (in_reg_eot),
    .st_next     (st_next),
    .res         (res_next),
    .res_valid   (res_fire)
  );

  // state moves only when the byte is actually consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= DEC_RESET;
    end else if (in_reg_valid && advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_reg_valid && res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_reg_valid && res_fire) begin
      res_q <= res_next;
    end
  end

  assign byte0      = res_q.byte0;
  assign byte1      = res_q.byte1;
  assign byte2      = res_q.byte2;
  assign count      = res_q.count;
  assign kind       = res_q.kind;
  assign error_code = res_q.error_code;

endmodule

FILE: rtl/jsu_checker.sv
// port-level checker for the json string unescaper, bound to the top level
`include "json_string_unescape_assert.svh"

module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_byte,
  input logic       end_of_text,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] byte0,
  input logic [7:0] byte1,
  input logic [7:0] byte2,
  input logic [1:0] count,
  input logic [1:0] kind,
  input logic [2:0] error_code
);
  import jsu_pkg::*;

  logic [8:0]  in_word;
  logic [30:0] out_word;

  assign in_word  = {in_byte, end_of_text};
  assign out_word = {byte0, byte1, byte2, count, kind, error_code};

  // a stalled input word keeps its contents
  `JSU_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && in_stall, in_valid && $stable(in_word))
  // a stalled output word keeps its contents
  `JSU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_word))
  // close and error words carry no decoded bytes
  `JSU_ASSERT_NOW(a_no_bytes, clk, rst, out_valid && kind != KIND_DATA, count == 2'd0)
  // data words always carry at least one byte
  `JSU_ASSERT_NOW(a_data_bytes, clk, rst, out_valid && kind == KIND_DATA, count != 2'd0)
  // error code is zero unless the word reports an error
  `JSU_ASSERT_NOW(a_err_clear, clk, rst, out_valid && kind != KIND_ERROR, error_code == '0)

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (.*);
